/* design/fadd_pkg.sv */
// Shared types and constants for the fraction adder with gcd reduction.
`default_nettype none
package fadd_pkg;

  // Widths of the item fields.
  localparam int unsigned InW     = 16;
  localparam int unsigned NumOutW = 33;
  localparam int unsigned DenOutW = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_den;
    logic mul_t1;
    logic mul_t2;
    logic sum;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_sel_den;
    logic save_rn;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_done;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

/* design/fadd_ctrl.sv */
// Controller state machine for the fraction adder.
`default_nettype none
module fadd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire fadd_pkg::status_t status_i,
  output fadd_pkg::cmd_t        cmd_o
);

  typedef enum logic [12:0] {
    StIdle    = 13'b0000000000001,
    StMulDen  = 13'b0000000000010,
    StMulT1   = 13'b0000000000100,
    StMulT2   = 13'b0000000001000,
    StSum     = 13'b0000000010000,
    StGcdInit = 13'b0000000100000,
    StGcd     = 13'b0000001000000,
    StDivNIni = 13'b0000010000000,
    StDivN    = 13'b0000100000000,
    StDivDIni = 13'b0001000000000,
    StDivD    = 13'b0010000000000,
    StFin     = 13'b0100000000000,
    StDone    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  // A new item is taken when idle or while the finished result leaves.
  assign in_ready_o  = (state_q == StIdle) || ((state_q == StDone) && out_ready_i);
  assign out_valid_o = (state_q == StDone);
  assign take        = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (take) begin
          cmd_o.load = 1'b1;
          state_d    = StMulDen;
        end
      end
      StMulDen: begin
        cmd_o.mul_den = 1'b1;
        state_d       = StMulT1;
      end
      StMulT1: begin
        cmd_o.mul_t1 = 1'b1;
        state_d      = StMulT2;
      end
      StMulT2: begin
        cmd_o.mul_t2 = 1'b1;
        state_d      = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StGcdInit;
      end
      StGcdInit: begin
        if (status_i.den_zero || status_i.num_zero) begin
          state_d = StFin;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = StGcd;
        end
      end
      StGcd: begin
        cmd_o.gcd_step = 1'b1;
        if (status_i.gcd_done) begin
          state_d = StDivNIni;
        end
      end
      StDivNIni: begin
        cmd_o.div_init = 1'b1;
        state_d        = StDivN;
      end
      StDivN: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StDivDIni;
        end
      end
      StDivDIni: begin
        cmd_o.save_rn     = 1'b1;
        cmd_o.div_init    = 1'b1;
        cmd_o.div_sel_den = 1'b1;
        state_d           = StDivD;
      end
      StDivD: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (take) begin
          cmd_o.load = 1'b1;
          state_d    = StMulDen;
        end else if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/fadd_datapath.sv */
// Datapath: shared multiplier, binary gcd unit and restoring divider.
`default_nettype none
module fadd_datapath #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire fadd_pkg::cmd_t                        cmd_i,
  output fadd_pkg::status_t                          status_o,
  input  wire logic signed [fadd_pkg::InW-1:0]       first_num_i,
  input  wire logic signed [fadd_pkg::InW-1:0]       first_den_i,
  input  wire logic signed [fadd_pkg::InW-1:0]       second_num_i,
  input  wire logic signed [fadd_pkg::InW-1:0]       second_den_i,
  output logic signed [fadd_pkg::NumOutW-1:0]        sum_num_o,
  output logic [fadd_pkg::DenOutW-1:0]               sum_den_o,
  output logic signed [fadd_pkg::NumOutW-1:0]        reduced_num_o,
  output logic [fadd_pkg::DenOutW-1:0]               reduced_den_o,
  output logic                                       zero_denominator_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned MW = 2 * W + 1;
  localparam int unsigned XW = (MW > fadd_pkg::NumOutW) ? MW : fadd_pkg::NumOutW;
  localparam int unsigned CW = $clog2(MW + 1);

  logic [W-1:0]  n1_v, d1_v, n2_v, d2_v;
  logic [W-1:0]  n1m_q, d1m_q, n2m_q, d2m_q;
  logic          n1s_q, d1s_q, n2s_q, d2s_q;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic [PW-1:0] den_q, t1_q, t2_q;
  logic          t1s, t2s, neg_pre;
  logic [MW-1:0] t1x, t2x, mag_pre;
  logic [MW-1:0] num_q;
  logic          neg_q;
  logic [MW-1:0] a_q, b_q, g_q, quo_q, rn_q;
  logic [CW-1:0] k_q, cnt_q;
  logic [MW:0]   rem_sh;
  logic [MW-1:0] rem_q;
  logic          rem_ge;
  logic [XW-1:0] num_x, rn_x, den_x, rd_x;

  // Operands: low bits of each field, split into sign and magnitude.
  assign n1_v = W'($unsigned(first_num_i));
  assign d1_v = W'($unsigned(first_den_i));
  assign n2_v = W'($unsigned(second_num_i));
  assign d2_v = W'($unsigned(second_den_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n1s_q <= n1_v[W-1];
      d1s_q <= d1_v[W-1];
      n2s_q <= n2_v[W-1];
      d2s_q <= d2_v[W-1];
      n1m_q <= n1_v[W-1] ? (~n1_v + W'(1)) : n1_v;
      d1m_q <= d1_v[W-1] ? (~d1_v + W'(1)) : d1_v;
      n2m_q <= n2_v[W-1] ? (~n2_v + W'(1)) : n2_v;
      d2m_q <= d2_v[W-1] ? (~d2_v + W'(1)) : d2_v;
    end
  end

  // One shared multiplier forms the three products in turn.
  always_comb begin
    mul_a = d1m_q;
    mul_b = d2m_q;
    if (cmd_i.mul_t1) begin
      mul_a = n1m_q;
    end else if (cmd_i.mul_t2) begin
      mul_a = n2m_q;
      mul_b = d1m_q;
    end
  end
  assign prod = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_den) begin
      den_q <= prod;
    end
    if (cmd_i.mul_t1) begin
      t1_q <= prod;
    end
    if (cmd_i.mul_t2) begin
      t2_q <= prod;
    end
  end

  // Signed sum of the cross products in sign and magnitude form.
  assign t1s = (n1s_q ^ d2s_q) && (t1_q != '0);
  assign t2s = (n2s_q ^ d1s_q) && (t2_q != '0);
  assign t1x = MW'(t1_q);
  assign t2x = MW'(t2_q);

  always_comb begin
    if (t1s == t2s) begin
      neg_pre = t1s;
      mag_pre = t1x + t2x;
    end else if (t1x >= t2x) begin
      neg_pre = t1s;
      mag_pre = t1x - t2x;
    end else begin
      neg_pre = t2s;
      mag_pre = t2x - t1x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      num_q <= mag_pre;
      neg_q <= (neg_pre ^ (d1s_q ^ d2s_q)) && (mag_pre != '0);
    end
  end

  // Binary gcd: strip common factors of two, then subtract odd values.
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      a_q <= num_q;
      b_q <= MW'(den_q);
      k_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (a_q == b_q) begin
        g_q <= MW'(a_q << k_q);
      end else if (!a_q[0] && !b_q[0]) begin
        a_q <= a_q >> 1;
        b_q <= b_q >> 1;
        k_q <= k_q + CW'(1);
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end
  end

  // Restoring division by the gcd, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[MW-1]};
  assign rem_ge = rem_sh >= {1'b0, g_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_rn) begin
      rn_q <= quo_q;
    end
    if (cmd_i.div_init) begin
      quo_q <= cmd_i.div_sel_den ? MW'(den_q) : num_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? MW'(rem_sh - {1'b0, g_q}) : rem_sh[MW-1:0];
      quo_q <= {quo_q[MW-2:0], rem_ge};
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Output fields keep the low bits of the signed results.
  assign num_x = XW'(num_q);
  assign rn_x  = XW'(rn_q);
  assign den_x = XW'(den_q);
  assign rd_x  = XW'(quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      zero_denominator_o <= status_o.den_zero;
      if (status_o.den_zero) begin
        sum_num_o     <= '0;
        sum_den_o     <= '0;
        reduced_num_o <= '0;
        reduced_den_o <= '0;
      end else begin
        sum_num_o <= fadd_pkg::NumOutW'(neg_q ? (~num_x + XW'(1)) : num_x);
        sum_den_o <= fadd_pkg::DenOutW'(den_x);
        if (status_o.num_zero) begin
          reduced_num_o <= '0;
          reduced_den_o <= fadd_pkg::DenOutW'(1);
        end else begin
          reduced_num_o <= fadd_pkg::NumOutW'(neg_q ? (~rn_x + XW'(1)) : rn_x);
          reduced_den_o <= fadd_pkg::DenOutW'(rd_x);
        end
      end
    end
  end

  // Status toward the controller.
  assign status_o.den_zero = (den_q == '0);
  assign status_o.num_zero = (num_q == '0);
  assign status_o.gcd_done = (a_q == b_q);
  assign status_o.div_last = (cnt_q == CW'(MW - 1));

endmodule
`default_nettype wire

/* design/fraction_add_reduce.sv */
// Each item passes through the products and sum, then the binary gcd loop (one step a
// cycle), then two restoring divisions, numerator first and then denominator, then the
// finish step; a zero sum or zero denominator skips the gcd and divisions. The block
// takes one item at a time: a new item is taken only while idle or while the last
// result leaves. Reset clears the controller only.
// Top level: fraction addition with gcd reduction.
`default_nettype none
module fraction_add_reduce #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [fadd_pkg::InW-1:0]     first_num_i,
  input  wire logic signed [fadd_pkg::InW-1:0]     first_den_i,
  input  wire logic signed [fadd_pkg::InW-1:0]     second_num_i,
  input  wire logic signed [fadd_pkg::InW-1:0]     second_den_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [fadd_pkg::NumOutW-1:0]      sum_num_o,
  output logic [fadd_pkg::DenOutW-1:0]             sum_den_o,
  output logic signed [fadd_pkg::NumOutW-1:0]      reduced_num_o,
  output logic [fadd_pkg::DenOutW-1:0]             reduced_den_o,
  output logic                                     zero_denominator_o
);

  fadd_pkg::cmd_t    cmd;
  fadd_pkg::status_t status;

  // Sequencing of each item.
  fadd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and result registers.
  fadd_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .first_num_i        (first_num_i),
    .first_den_i        (first_den_i),
    .second_num_i       (second_num_i),
    .second_den_i       (second_den_i),
    .sum_num_o          (sum_num_o),
    .sum_den_o          (sum_den_o),
    .reduced_num_o      (reduced_num_o),
    .reduced_den_o      (reduced_den_o),
    .zero_denominator_o (zero_denominator_o)
  );

endmodule
`default_nettype wire

/* sim/fraction_add_reduce_test.sv */
// Self-checking testbench for the fraction adder with gcd reduction.
`default_nettype none
module fraction_add_reduce_test;

  // Expected result of one fraction sum.
  typedef struct packed {
    logic signed [fadd_pkg::NumOutW-1:0] sum_num;
    logic [fadd_pkg::DenOutW-1:0]        sum_den;
    logic signed [fadd_pkg::NumOutW-1:0] red_num;
    logic [fadd_pkg::DenOutW-1:0]        red_den;
    logic                                zero_den;
  } frac_sum_t;

  // One directed row: operands, and an optional typed-in result.
  typedef struct {
    logic signed [fadd_pkg::InW-1:0] n1, d1, n2, d2;
    bit                              known;
    frac_sum_t                       res;
  } frac_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [fadd_pkg::InW-1:0] first_num_i = '0, first_den_i = '0;
  logic signed [fadd_pkg::InW-1:0] second_num_i = '0, second_den_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [fadd_pkg::NumOutW-1:0] sum_num_o, reduced_num_o;
  logic [fadd_pkg::DenOutW-1:0] sum_den_o, reduced_den_o;
  logic zero_denominator_o;

  frac_sum_t pending_sums[$];
  int errors = 0;
  int sums_checked = 0;
  int zero_den_seen = 0;
  int zero_sum_seen = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;

  fraction_add_reduce u_top (.*);

  // Clock with a period of 4.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicts the reduced sum of n1/d1 + n2/d2.
  function automatic frac_sum_t add_fractions(logic signed [fadd_pkg::InW-1:0] n1, d1, n2,
                                              d2);
    frac_sum_t r;
    longint num, den, a, b, t;
    r = '0;
    den = longint'(d1) * longint'(d2);
    if (den == 0) begin
      r.zero_den = 1'b1;
      return r;
    end
    num = longint'(n1) * longint'(d2) + longint'(n2) * longint'(d1);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    r.sum_num = num[fadd_pkg::NumOutW-1:0];
    r.sum_den = den[fadd_pkg::DenOutW-1:0];
    if (num == 0) begin
      r.red_den = fadd_pkg::DenOutW'(1);
      return r;
    end
    a = (num < 0) ? -num : num;
    b = den;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    t = num / a;
    r.red_num = t[fadd_pkg::NumOutW-1:0];
    t = den / a;
    r.red_den = t[fadd_pkg::DenOutW-1:0];
    return r;
  endfunction

  // Offers one item; waits for its transfer.
  task automatic send_fractions(logic signed [fadd_pkg::InW-1:0] n1, d1, n2, d2);
    first_num_i  = n1;
    first_den_i  = d1;
    second_num_i = n2;
    second_den_i = d2;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_sums.push_back(add_fractions(n1, d1, n2, d2));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic idle_sender();
    repeat ($urandom_range(0, 14)) @(negedge clk_i);
  endtask

  // Random operand: often full range or small, sometimes extreme or zero.
  function automatic logic signed [fadd_pkg::InW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3, 4, 5: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed rows, then random items with sender gaps.
  initial begin
    frac_row_t rows[$];
    frac_row_t row;
    logic signed [fadd_pkg::InW-1:0] a, b, c, d;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // Zero denominator on either side gives the flag and zero fields.
    row = '{16'sd3, 16'sd0, 16'sd1, 16'sd2, 1'b1, '{0, 0, 0, 0, 1'b1}};
    rows.push_back(row);
    row = '{16'sd3, 16'sd5, 16'sd1, 16'sd0, 1'b1, '{0, 0, 0, 0, 1'b1}};
    rows.push_back(row);
    // Zero sum gives 0/1.
    row = '{16'sd1, 16'sd2, -16'sd1, 16'sd2, 1'b1, '{0, 4, 0, 1, 1'b0}};
    rows.push_back(row);
    row = '{16'sd0, 16'sd7, 16'sd0, -16'sd3, 1'b1, '{0, 21, 0, 1, 1'b0}};
    rows.push_back(row);
    // 1/2 + 1/2 = 4/4 = 1/1.
    row = '{16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, '{4, 4, 1, 1, 1'b0}};
    rows.push_back(row);
    // Negative denominator moves its sign to the numerator.
    row = '{16'sd1, -16'sd2, 16'sd0, 16'sd1, 1'b1, '{-1, 2, -1, 2, 1'b0}};
    rows.push_back(row);
    // Extremes, checked against the predictor.
    a = 16'sh8000;
    b = 16'sh7fff;
    row = '{a, a, a, a, 1'b0, '0}; rows.push_back(row);
    row = '{b, b, b, b, 1'b0, '0}; rows.push_back(row);
    row = '{a, b, b, a, 1'b0, '0}; rows.push_back(row);
    row = '{b, a, a, b, 1'b0, '0}; rows.push_back(row);
    row = '{a, -16'sd1, a, 16'sd1, 1'b0, '0}; rows.push_back(row);
    row = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, '0}; rows.push_back(row);
    row = '{16'sd6, 16'sd9, 16'sd10, -16'sd15, 1'b0, '0}; rows.push_back(row);
    row = '{b, 16'sd1, b, 16'sd1, 1'b0, '0}; rows.push_back(row);
    foreach (rows[i]) begin
      send_fractions(rows[i].n1, rows[i].d1, rows[i].n2, rows[i].d2);
      if (rows[i].known && pending_sums[$] != rows[i].res) begin
        $display("%0t: table row %0d expected %h, predictor %h", $time, i,
                 rows[i].res, pending_sums[$]);
        errors++;
      end
      idle_sender();
    end
    // Random part: a long receiver hold-off early on fills the block.
    for (int i = 0; i < 1040; i++) begin
      if (i == 20) hold_off = 400;
      if (i == 500) begin
        wait (pending_sums.size() == 0);
        @(negedge clk_i);
      end
      a = pick_operand();
      b = pick_operand();
      c = pick_operand();
      d = pick_operand();
      // Keep zero denominators occasional; force zero sums now and then.
      if (d == 0 && $urandom_range(0, 3) != 0) d = 16'sd1;
      if (b == 0 && $urandom_range(0, 3) != 0) b = -16'sd1;
      if ($urandom_range(0, 15) == 0) begin
        c = -a;
        d = b;
      end
      send_fractions(a, b, c, d);
      if ($urandom_range(0, 3) != 0) idle_sender();
    end
    stim_done = 1'b1;
  end

  // Receiver: a random wait before each result, plus the long hold-off.
  initial begin
    int unsigned gap;
    @(negedge clk_i);
    forever begin
      gap = $urandom_range(0, 14);
      repeat (gap) begin
        out_ready_i <= 1'b0;
        @(negedge clk_i);
      end
      while (hold_off > 0) begin
        out_ready_i <= 1'b0;
        hold_off--;
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  // Compares each result transfer with the oldest expected sum.
  always @(posedge clk_i) begin
    frac_sum_t exp_sum;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result %h/%h", $time, sum_num_o, sum_den_o);
        errors++;
      end else begin
        exp_sum = pending_sums.pop_front();
        sums_checked++;
        if (exp_sum.zero_den) zero_den_seen++;
        else if (exp_sum.sum_num == 0) zero_sum_seen++;
        if (sum_num_o !== exp_sum.sum_num) begin
          $display("%0t: sum_num expected %0d, got %0d", $time, exp_sum.sum_num, sum_num_o);
          errors++;
        end
        if (sum_den_o !== exp_sum.sum_den) begin
          $display("%0t: sum_den expected %0d, got %0d", $time, exp_sum.sum_den, sum_den_o);
          errors++;
        end
        if (reduced_num_o !== exp_sum.red_num) begin
          $display("%0t: reduced_num expected %0d, got %0d", $time, exp_sum.red_num,
                   reduced_num_o);
          errors++;
        end
        if (reduced_den_o !== exp_sum.red_den) begin
          $display("%0t: reduced_den expected %0d, got %0d", $time, exp_sum.red_den,
                   reduced_den_o);
          errors++;
        end
        if (zero_denominator_o !== exp_sum.zero_den) begin
          $display("%0t: zero_denominator expected %0b, got %0b", $time, exp_sum.zero_den,
                   zero_denominator_o);
          errors++;
        end
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    wait (stim_done);
    wait (pending_sums.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("Checked %0d sums: %0d with a zero denominator, %0d with a zero sum.",
             sums_checked, zero_den_seen, zero_sum_seen);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Timeout.
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
